// ===== rtl/curved_line_interpolator_top_assert.svh =====
// ----------------------------------------------------------------------------
// Curved line interpolator assertion macros
// Shared property forms for the checker of the top level.
// ----------------------------------------------------------------------------
`ifndef CURVED_LINE_INTERPOLATOR_TOP_ASSERT_SVH
`define CURVED_LINE_INTERPOLATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define CVI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define CVI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cvi_pkg.sv =====
// ----------------------------------------------------------------------------
// Curved line interpolator package
// Types and fixed constants shared by the interpolator files.
// ----------------------------------------------------------------------------
package cvi_pkg;

  localparam int VALUE_BITS      = 32;  // Q16.16 values
  localparam int CFG_DATA_BITS   = 32;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int LINE_FIELD_BITS = 16;  // line registers keep 16 bits
  localparam int MODE_BITS       = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_START_LINE  = 3'd0,
    REG_END_LINE    = 3'd1,
    REG_START_VALUE = 3'd2,
    REG_END_VALUE   = 3'd3,
    REG_CURVE_MODE  = 3'd4
  } reg_index_t;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_LINEAR   = 3'd0,
    MODE_SQUARE   = 3'd1,
    MODE_LOG      = 3'd2,
    MODE_CUBE     = 3'd3,
    MODE_EASE_OUT = 3'd4,
    MODE_SMOOTH   = 3'd5
  } mode_t;

  // Which answer a beat carries down the pipe.
  typedef enum logic [1:0] {
    SEL_RAMP  = 2'd0,
    SEL_START = 2'd1,
    SEL_END   = 2'd2
  } sel_t;

endpackage

// ===== rtl/cvi_if.sv =====
// ----------------------------------------------------------------------------
// Curved line interpolator channels
// Valid/ready channels for line requests and interpolated values.
// ----------------------------------------------------------------------------
interface cvi_line_if #(parameter int LINE_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic [LINE_BITS-1:0] line_index;

  modport source (output valid, output line_index, input ready);
  modport sink   (input valid, input line_index, output ready);
endinterface

interface cvi_value_if;
  import cvi_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/curved_line_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// Curved line interpolator
// Maps a line index to a value on a shaped ramp between two configured points.
// ----------------------------------------------------------------------------
// Takes one line index per clock while the pipe has room and returns one
// Q16.16 value per index, in order. The pipe is the entry register, then the
// position divider, which resolves one quotient bit per stage; after it come
// two shaping multiplies, a curve select, the scale multiply, rounding and
// the final add. Each stage moves on its own, so bubbles close up under
// back-pressure and a new index is taken whenever a free slot exists anywhere
// down the pipe. Registers (start_line, end_line,
// start_value, end_value, curve_mode at indexes 0..4) are written through
// cfg_we/cfg_index/cfg_data and must only change while the pipe is empty.
// At or below start_line the answer is start_value, at or above end_line it
// is end_value; curve codes 6 and 7 behave as linear.
// ----------------------------------------------------------------------------
module curved_line_interpolator_top #(
  parameter int LINE_BITS     = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  cvi_line_if.sink                            line_ch,
  cvi_value_if.source                         value_ch,
  input  logic                                cfg_we,
  input  logic [cvi_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [cvi_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import cvi_pkg::*;

  // Shaped operands run up to 3.0, so two integer bits over the fraction.
  localparam int TW = FRACTION_BITS + 2;
  // Shaped value is at most 1.0.
  localparam int SW = FRACTION_BITS + 1;
  // Scale product width.
  localparam int PW = SW + VALUE_BITS;

  localparam logic [TW-1:0] One   = TW'(1) << FRACTION_BITS;
  localparam logic [TW-1:0] Two   = TW'(2) << FRACTION_BITS;
  localparam logic [TW-1:0] Three = TW'(3) << FRACTION_BITS;
  localparam logic [PW-1:0] RoundAdd = (PW'(1) << FRACTION_BITS) - PW'(1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [LINE_BITS-1:0]         start_line;
  logic [LINE_BITS-1:0]         end_line;
  logic [VALUE_BITS-1:0]        start_value;
  logic [VALUE_BITS-1:0]        end_value;
  logic [MODE_BITS-1:0]         curve_mode;
  mode_t                        mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_line  <= '0;
      end_line    <= '0;
      start_value <= '0;
      end_value   <= '0;
      curve_mode  <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_START_LINE:  start_line  <= LINE_BITS'(cfg_data[LINE_FIELD_BITS-1:0]);
        REG_END_LINE:    end_line    <= LINE_BITS'(cfg_data[LINE_FIELD_BITS-1:0]);
        REG_START_VALUE: start_value <= cfg_data[VALUE_BITS-1:0];
        REG_END_VALUE:   end_value   <= cfg_data[VALUE_BITS-1:0];
        REG_CURVE_MODE:  curve_mode  <= cfg_data[MODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign mode = mode_t'(curve_mode);

  // Values derived from the registers, refreshed every cycle. Items reach the
  // stages that use them well after any write settles.
  logic [LINE_BITS-1:0]  span;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic [VALUE_BITS:0]   rise;
  logic [VALUE_BITS:0]   fall;

  assign rise = {end_value[VALUE_BITS-1], end_value}
              - {start_value[VALUE_BITS-1], start_value};
  assign fall = {start_value[VALUE_BITS-1], start_value}
              - {end_value[VALUE_BITS-1], end_value};

  always_ff @(posedge clk) begin
    span <= end_line - start_line;
    neg  <= rise[VALUE_BITS];
    mag  <= rise[VALUE_BITS] ? fall[VALUE_BITS-1:0] : rise[VALUE_BITS-1:0];
  end

  // --------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its successor loads.
  // --------------------------------------------------------------------------
  logic e_vld, m1_vld, m2_vld, sh_vld, m3_vld, rn_vld, o_vld;
  logic e_en, m1_en, m2_en, sh_en, m3_en, rn_en, o_en;
  logic div_in_ready, div_out_valid;

  assign o_en  = !o_vld  || value_ch.ready;
  assign rn_en = !rn_vld || o_en;
  assign m3_en = !m3_vld || rn_en;
  assign sh_en = !sh_vld || m3_en;
  assign m2_en = !m2_vld || sh_en;
  assign m1_en = !m1_vld || m2_en;
  assign e_en  = !e_vld  || div_in_ready;

  assign line_ch.ready = e_en;

  // --------------------------------------------------------------------------
  // Entry: classify the line and form the divider's dividend.
  // --------------------------------------------------------------------------
  sel_t                 e_sel;
  sel_t                 in_sel;
  logic [LINE_BITS-1:0] e_rem;

  always_comb begin
    if (line_ch.line_index <= start_line) begin
      in_sel = SEL_START;
    end else if (line_ch.line_index >= end_line) begin
      in_sel = SEL_END;
    end else begin
      in_sel = SEL_RAMP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (e_en) begin
      e_vld <= line_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_en && line_ch.valid) begin
      e_sel <= in_sel;
      e_rem <= line_ch.line_index - start_line;
    end
  end

  // --------------------------------------------------------------------------
  // Position t in Q0.F, truncated.
  // --------------------------------------------------------------------------
  logic [FRACTION_BITS-1:0] d_t;
  sel_t                     d_sel;

  cvi_div #(
    .LINE_BITS     (LINE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (e_vld),
    .in_ready  (div_in_ready),
    .in_rem    (e_rem),
    .in_sel    (e_sel),
    .span      (span),
    .out_valid (div_out_valid),
    .out_ready (m1_en),
    .out_t     (d_t),
    .out_sel   (d_sel)
  );

  // --------------------------------------------------------------------------
  // First shaping multiply: t*t, t*(2-t) or u*u with u = 1-t.
  // --------------------------------------------------------------------------
  logic [TW-1:0]   d_tw, d_u, x1, y1, m1_t, m1_p1;
  logic [2*TW-1:0] prod1;
  sel_t            m1_sel;

  assign d_tw = TW'(d_t);
  assign d_u  = One - d_tw;

  always_comb begin
    x1 = d_tw;
    y1 = d_tw;
    case (mode)
      MODE_LOG:      y1 = Two - d_tw;
      MODE_EASE_OUT: begin
        x1 = d_u;
        y1 = d_u;
      end
      default: ;
    endcase
  end

  assign prod1 = (2*TW)'(x1) * (2*TW)'(y1);

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else if (m1_en) begin
      m1_vld <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m1_en && div_out_valid) begin
      m1_sel <= d_sel;
      m1_t   <= d_tw;
      m1_p1  <= TW'(prod1 >> FRACTION_BITS);
    end
  end

  // --------------------------------------------------------------------------
  // Second shaping multiply: t^2*t, u^2*u or t^2*(3-2t).
  // --------------------------------------------------------------------------
  logic [TW-1:0]   z2, m2_t, m2_p1, m2_p2;
  logic [2*TW-1:0] prod2;
  sel_t            m2_sel;

  always_comb begin
    case (mode)
      MODE_EASE_OUT: z2 = One - m1_t;
      MODE_SMOOTH:   z2 = Three - (m1_t << 1);
      default:       z2 = m1_t;
    endcase
  end

  assign prod2 = (2*TW)'(m1_p1) * (2*TW)'(z2);

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_vld <= 1'b0;
    end else if (m2_en) begin
      m2_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (m2_en && m1_vld) begin
      m2_sel <= m1_sel;
      m2_t   <= m1_t;
      m2_p1  <= m1_p1;
      m2_p2  <= TW'(prod2 >> FRACTION_BITS);
    end
  end

  // --------------------------------------------------------------------------
  // Curve select.
  // --------------------------------------------------------------------------
  logic [TW-1:0] sh_next;
  logic [SW-1:0] sh;
  sel_t          sh_sel;

  always_comb begin
    case (mode)
      MODE_SQUARE,
      MODE_LOG:      sh_next = m2_p1;
      MODE_CUBE,
      MODE_SMOOTH:   sh_next = m2_p2;
      MODE_EASE_OUT: sh_next = One - m2_p2;
      default:       sh_next = m2_t;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sh_vld <= 1'b0;
    end else if (sh_en) begin
      sh_vld <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (sh_en && m2_vld) begin
      sh_sel <= m2_sel;
      sh     <= SW'(sh_next);
    end
  end

  // --------------------------------------------------------------------------
  // Scale by |end - start|.
  // --------------------------------------------------------------------------
  logic [PW-1:0] m3_prod;
  sel_t          m3_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_vld <= 1'b0;
    end else if (m3_en) begin
      m3_vld <= sh_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (m3_en && sh_vld) begin
      m3_sel  <= sh_sel;
      m3_prod <= PW'(sh) * PW'(mag);
    end
  end

  // --------------------------------------------------------------------------
  // Floor to the Q16.16 grid: round the magnitude up when the slope falls.
  // --------------------------------------------------------------------------
  logic [PW-1:0]         rsum;
  logic [VALUE_BITS-1:0] rn_q;
  sel_t                  rn_sel;

  assign rsum = neg ? m3_prod + RoundAdd : m3_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      rn_vld <= 1'b0;
    end else if (rn_en) begin
      rn_vld <= m3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rn_en && m3_vld) begin
      rn_sel <= m3_sel;
      rn_q   <= VALUE_BITS'(rsum >> FRACTION_BITS);
    end
  end

  // --------------------------------------------------------------------------
  // Output register: final add or one of the end points.
  // --------------------------------------------------------------------------
  logic [VALUE_BITS-1:0] o_next;
  logic [VALUE_BITS-1:0] o_value;

  always_comb begin
    case (rn_sel)
      SEL_START: o_next = start_value;
      SEL_END:   o_next = end_value;
      default:   o_next = neg ? start_value - rn_q : start_value + rn_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (o_en) begin
      o_vld <= rn_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en && rn_vld) begin
      o_value <= o_next;
    end
  end

  assign value_ch.valid = o_vld;
  assign value_ch.value = o_value;

endmodule

// ===== rtl/cvi_div.sv =====
// ----------------------------------------------------------------------------
// Curved line interpolator divider
// Restoring divider, one quotient bit per stage, forms t = (rem << F) / span.
// ----------------------------------------------------------------------------
module cvi_div #(
  parameter int LINE_BITS     = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [LINE_BITS-1:0]     in_rem,
  input  cvi_pkg::sel_t            in_sel,
  input  logic [LINE_BITS-1:0]     span,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [FRACTION_BITS-1:0] out_t,
  output cvi_pkg::sel_t            out_sel
);
  import cvi_pkg::*;

  localparam int N = FRACTION_BITS;

  logic                 vld [N];
  logic                 en  [N+1];
  logic [LINE_BITS-1:0] rem [N];
  logic [N-1:0]         quo [N];
  sel_t                 sel [N];

  assign en[N] = out_ready;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                 src_vld;
    logic [LINE_BITS-1:0] src_rem;
    logic [N-1:0]         src_quo;
    sel_t                 src_sel;
    logic [LINE_BITS:0]   dbl;
    logic [LINE_BITS:0]   diff;
    logic                 ge;

    if (k == 0) begin : g_first
      assign src_vld = in_valid;
      assign src_rem = in_rem;
      assign src_quo = '0;
      assign src_sel = in_sel;
    end else begin : g_next
      assign src_vld = vld[k-1];
      assign src_rem = rem[k-1];
      assign src_quo = quo[k-1];
      assign src_sel = sel[k-1];
    end

    assign en[k] = !vld[k] || en[k+1];
    assign dbl   = {src_rem, 1'b0};
    assign ge    = dbl >= {1'b0, span};
    assign diff  = dbl - {1'b0, span};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k] && src_vld) begin
        rem[k] <= ge ? diff[LINE_BITS-1:0] : dbl[LINE_BITS-1:0];
        quo[k] <= {src_quo[N-2:0], ge};
        sel[k] <= src_sel;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[N-1];
  assign out_t     = quo[N-1];
  assign out_sel   = sel[N-1];

endmodule

// ===== rtl/cvi_checker.sv =====
// ----------------------------------------------------------------------------
// Curved line interpolator checker
// Port-level checks on the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "curved_line_interpolator_top_assert.svh"

module cvi_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [cvi_pkg::VALUE_BITS-1:0]  out_value
);
  import cvi_pkg::*;

  // A stalled result beat stays put.
  `CVI_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "beat dropped")
  `CVI_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_value), "beat moved")

  // With the output slot free, the pipe has room and must take a line.
  `CVI_ASSERT_SAME(a_in_room, clk, rst, !out_valid || out_ready, in_ready, "line refused")

  // Nothing comes out straight after reset.
  `CVI_ASSERT_SAME(a_reset_empty, clk, rst, $fell(rst), !out_valid, "beat present after reset")

  // An offered line beat stays offered until it is taken.
  `CVI_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !in_ready, in_valid, "line beat withdrawn")

endmodule

bind curved_line_interpolator_top cvi_checker u_cvi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (line_ch.valid),
  .in_ready  (line_ch.ready),
  .out_valid (value_ch.valid),
  .out_ready (value_ch.ready),
  .out_value (value_ch.value)
);

// ===== sim/tb_curved_line_interpolator_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Curved line interpolator testbench
// Drives line indexes through the interpolator under several register
// settings and handshake patterns. A scoreboard computes the expected Q16.16
// value of every accepted index and compares the output beats in order.
// ----------------------------------------------------------------------------
module tb_curved_line_interpolator_top;
  import cvi_pkg::*;

  localparam int LINE_BITS     = 16;
  localparam int FRACTION_BITS = 16;
  // Pipe depth in registers plus some margin.
  localparam int DRAIN_CYCLES  = FRACTION_BITS + 7 + 8;
  localparam int QUIET_LIMIT   = 2000;   // cycles with no beat and no write
  localparam int HOLD_CYCLES   = 300;    // long output hold-off
  localparam int MAX_REPORTS   = 10;

  // Register indexes past the last real register; writes there are dropped.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_FIRST = 3'd5;
  // Curve codes with no shape of their own; they fall back to linear.
  localparam logic [MODE_BITS-1:0] MODE_SPARE_HI = 3'd7;

  localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_BITS-1:0] VALUE_ONE = 32'sh0001_0000;

  typedef struct {
    logic [LINE_BITS-1:0]         s_line;
    logic [LINE_BITS-1:0]         e_line;
    logic signed [VALUE_BITS-1:0] s_val;
    logic signed [VALUE_BITS-1:0] e_val;
    logic [MODE_BITS-1:0]         mode;
  } ramp_cfg_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the registers, ramp predictor, in-order compare.
  // --------------------------------------------------------------------------
  class ramp_scoreboard;
    logic [LINE_BITS-1:0]         s_line;
    logic [LINE_BITS-1:0]         e_line;
    logic signed [VALUE_BITS-1:0] s_val;
    logic signed [VALUE_BITS-1:0] e_val;
    logic [MODE_BITS-1:0]         mode;
    logic signed [VALUE_BITS-1:0] expected_values[$];
    int unsigned                  beats_checked;
    int unsigned                  failures;

    function new();
      s_line = '0;
      e_line = '0;
      s_val  = '0;
      e_val  = '0;
      mode   = MODE_LINEAR;
      beats_checked = 0;
      failures      = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_BITS-1:0] idx,
                               logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_START_LINE:  s_line = data[LINE_BITS-1:0];
        REG_END_LINE:    e_line = data[LINE_BITS-1:0];
        REG_START_VALUE: s_val  = data;
        REG_END_VALUE:   e_val  = data;
        REG_CURVE_MODE:  mode   = data[MODE_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Q0.F times Q0.F, truncated right away.
    function logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b);
      return (a * b) >> FRACTION_BITS;
    endfunction

    function logic [63:0] shaped_position(logic [63:0] t);
      logic [63:0] one;
      logic [63:0] u;
      one = 64'd1 << FRACTION_BITS;
      u   = one - t;
      case (mode)
        MODE_SQUARE:   return frac_mul(t, t);
        MODE_LOG:      return frac_mul(t, 2 * one - t);
        MODE_CUBE:     return frac_mul(frac_mul(t, t), t);
        MODE_EASE_OUT: return one - frac_mul(frac_mul(u, u), u);
        MODE_SMOOTH:   return frac_mul(frac_mul(t, t), 3 * one - 2 * t);
        default:       return t;
      endcase
    endfunction

    function logic signed [VALUE_BITS-1:0] ramp_value(logic [LINE_BITS-1:0] line);
      logic [63:0] span;
      logic [63:0] t;
      logic [63:0] sh;
      logic [63:0] mag;
      logic [63:0] prod;
      logic [63:0] q;
      longint      diff;
      longint      res;
      if (line <= s_line) return s_val;
      if (line >= e_line) return e_val;
      span = 64'(e_line) - 64'(s_line);
      t    = ((64'(line) - 64'(s_line)) << FRACTION_BITS) / span;
      sh   = shaped_position(t);
      diff = longint'(e_val) - longint'(s_val);
      if (diff < 0) begin
        // floor of a negative step rounds the magnitude up
        mag  = -diff;
        prod = sh * mag;
        q    = (prod + ((64'd1 << FRACTION_BITS) - 1)) >> FRACTION_BITS;
        res  = longint'(s_val) - longint'(q);
      end else begin
        mag  = diff;
        prod = sh * mag;
        q    = prod >> FRACTION_BITS;
        res  = longint'(s_val) + longint'(q);
      end
      return res[VALUE_BITS-1:0];
    endfunction

    function void note_line(logic [LINE_BITS-1:0] line);
      expected_values.push_back(ramp_value(line));
    endfunction

    function void check_value(logic signed [VALUE_BITS-1:0] got);
      logic signed [VALUE_BITS-1:0] want;
      if (expected_values.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("value beat %0d (0x%08h) with nothing outstanding", got, got);
        return;
      end
      want = expected_values.pop_front();
      beats_checked++;
      if (got !== want) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("value beat %0d: expected %0d (0x%08h), got %0d (0x%08h)",
                   beats_checked, want, want, got, got);
      end
    endfunction

    function int pending();
      return expected_values.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block.
  // --------------------------------------------------------------------------
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_data = '0;

  cvi_line_if #(.LINE_BITS(LINE_BITS)) line_ch ();
  cvi_value_if                         value_ch ();

  curved_line_interpolator_top #(
    .LINE_BITS     (LINE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .line_ch   (line_ch),
    .value_ch  (value_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ramp_scoreboard sb = new();

  int unsigned send_idle_pct  = 0;  // chance per cycle that the sender idles
  int unsigned recv_stall_pct = 0;  // chance per cycle that ready drops
  int unsigned hold_left      = 0;  // remaining cycles of a forced hold-off
  int unsigned settings_seen  = 0;
  int unsigned quiet_cycles   = 0;

  // --------------------------------------------------------------------------
  // Monitor: every accepted beat and register write is sampled at the edge,
  // before the NBA updates of that edge land.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (line_ch.valid && line_ch.ready) sb.note_line(line_ch.line_index);
      if (value_ch.valid && value_ch.ready) sb.check_value(value_ch.value);
      if (cfg_we) sb.set_register(cfg_index, cfg_data);
    end
  end

  // Watchdog: only stretches with no traffic at all count against the limit.
  always @(posedge clk) begin
    if (rst || cfg_we || (line_ch.valid && line_ch.ready) ||
        (value_ch.valid && value_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("watchdog: no traffic for %0d cycles", QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Output side: random stalls, or a counted hold-off when one is requested.
  initial begin
    value_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        value_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        value_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks.
  // --------------------------------------------------------------------------
  // One line beat; valid stays high into the next call unless it idles.
  task automatic send_line(input logic [LINE_BITS-1:0] line);
    while ($urandom_range(99) < send_idle_pct) begin
      line_ch.valid <= 1'b0;
      @(posedge clk);
    end
    line_ch.valid      <= 1'b1;
    line_ch.line_index <= line;
    forever begin
      @(posedge clk);
      if (line_ch.ready) break;
    end
  endtask

  // Stop offering and wait for every outstanding value to come back.
  task automatic drain();
    line_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all five registers, then one spare index that must be dropped.
  // Unused upper data bits carry noise.
  task automatic load_ramp(input ramp_cfg_t c);
    logic [31:0] noise;
    noise = $urandom();
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_LINE;
    cfg_data  <= {noise[31:16], c.s_line};
    @(posedge clk);
    noise = $urandom();
    cfg_index <= REG_END_LINE;
    cfg_data  <= {noise[31:16], c.e_line};
    @(posedge clk);
    cfg_index <= REG_START_VALUE;
    cfg_data  <= c.s_val;
    @(posedge clk);
    cfg_index <= REG_END_VALUE;
    cfg_data  <= c.e_val;
    @(posedge clk);
    noise = $urandom();
    cfg_index <= REG_CURVE_MODE;
    cfg_data  <= {noise[31:3], c.mode};
    @(posedge clk);
    cfg_index <= REG_SPARE_FIRST + 3'($urandom_range(2));
    cfg_data  <= $urandom();
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_seen++;
  endtask

  function automatic ramp_cfg_t make_ramp(logic [LINE_BITS-1:0] s_line,
                                          logic [LINE_BITS-1:0] e_line,
                                          logic signed [VALUE_BITS-1:0] s_val,
                                          logic signed [VALUE_BITS-1:0] e_val,
                                          logic [MODE_BITS-1:0] mode);
    ramp_cfg_t c;
    c.s_line = s_line;
    c.e_line = e_line;
    c.s_val  = s_val;
    c.e_val  = e_val;
    c.mode   = mode;
    return c;
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] rand_value();
    int r;
    r = $urandom_range(99);
    if (r < 15) return VALUE_MIN;
    if (r < 30) return VALUE_MAX;
    if (r < 38) return '0;
    return $urandom();
  endfunction

  // Mostly proper ramps; a few full-range, equal, reversed and tiny spans.
  function automatic ramp_cfg_t rand_ramp();
    ramp_cfg_t            c;
    logic [LINE_BITS-1:0] a;
    logic [LINE_BITS-1:0] b;
    int                   kind;
    kind = $urandom_range(9);
    a = LINE_BITS'($urandom());
    b = LINE_BITS'($urandom());
    case (kind)
      0: begin
        c.s_line = '0;
        c.e_line = '1;
      end
      1: begin
        c.s_line = a;
        c.e_line = a;
      end
      2: begin
        c.s_line = (a > b) ? a : b;
        c.e_line = (a > b) ? b : a;
      end
      3: begin
        c.s_line = LINE_BITS'($urandom_range(16'hFFF0));
        c.e_line = c.s_line + LINE_BITS'($urandom_range(1, 8));
      end
      default: begin
        c.s_line = (a < b) ? a : b;
        c.e_line = (a < b) ? b : a;
      end
    endcase
    c.s_val = rand_value();
    c.e_val = rand_value();
    c.mode  = MODE_BITS'($urandom_range(7));
    return c;
  endfunction

  // Lines mostly inside the ramp, some on or just past its ends, some anywhere.
  function automatic logic [LINE_BITS-1:0] rand_line(ramp_cfg_t c);
    logic [LINE_BITS-1:0] lo;
    logic [LINE_BITS-1:0] hi;
    int                   r;
    lo = (c.s_line < c.e_line) ? c.s_line : c.e_line;
    hi = (c.s_line < c.e_line) ? c.e_line : c.s_line;
    r  = $urandom_range(99);
    if (r < 12) return LINE_BITS'($urandom());
    if (r < 18) return c.s_line;
    if (r < 24) return c.e_line;
    if (r < 29) return lo - LINE_BITS'($urandom_range(3));
    if (r < 34) return hi + LINE_BITS'($urandom_range(3));
    return lo + LINE_BITS'($urandom_range(32'(hi - lo)));
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  int unsigned send_idle_of[4]  = '{0, 55, 0, 13};
  int unsigned recv_stall_of[4] = '{0, 0, 55, 13};

  initial begin
    ramp_cfg_t c;
    line_ch.valid      = 1'b0;
    line_ch.line_index = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: out of reset every register is zero, so both ends give zero.
    send_line('0);
    send_line('1);
    drain();

    // Full line range, full value swing, linear: near the ends and the midpoint.
    c = make_ramp('0, '1, VALUE_MIN, VALUE_MAX, MODE_LINEAR);
    load_ramp(c);
    send_line(16'h0001);
    send_line(16'h7FFF);
    send_line(16'hFFFE);
    send_line(16'hFFFF);
    drain();

    // Every other curve code at mid-ramp, spare codes included.
    for (int m = MODE_SQUARE; m <= MODE_SPARE_HI; m++) begin
      c.mode = MODE_BITS'(m);
      load_ramp(c);
      send_line(16'h8000);
      drain();
    end

    // Falling ramp: negative step must floor, not truncate.
    load_ramp(make_ramp('0, '1, VALUE_MAX, VALUE_MIN, MODE_SMOOTH));
    send_line(16'h0001);
    send_line(16'hAAAA);
    drain();

    // Equal start and end lines: start value up to the line, end value past.
    load_ramp(make_ramp(16'd500, 16'd500, VALUE_ONE, -3 * VALUE_ONE, MODE_CUBE));
    send_line(16'd499);
    send_line(16'd500);
    send_line(16'd501);
    drain();

    // Start line after end line: same split, no ramp in between.
    load_ramp(make_ramp(16'd900, 16'd100, -VALUE_ONE, 7 * VALUE_ONE, MODE_EASE_OUT));
    send_line(16'd50);
    send_line(16'd900);
    send_line(16'd901);
    drain();

    // Narrowest ramp with an interior point: t is exactly one half.
    load_ramp(make_ramp(16'd10, 16'd12, '0, VALUE_ONE, MODE_LOG));
    send_line(16'd11);
    drain();

    // Random part: four handshake patterns, several settings each.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_idle_of[phase];
      recv_stall_pct = recv_stall_of[phase];
      for (int set = 0; set < 6; set++) begin
        c = rand_ramp();
        load_ramp(c);
        for (int n = 0; n < 52; n++) send_line(rand_line(c));
        drain();
      end

      // Back-pressure: hold the output off while lines keep coming, so the
      // pipe fills and the input side has to stall.
      if (phase == 0) begin
        c = make_ramp(16'd1000, 16'd3000, VALUE_MIN, VALUE_MAX, MODE_SMOOTH);
        load_ramp(c);
        hold_left = HOLD_CYCLES;
        for (int n = 0; n < 80; n++) send_line(rand_line(c));
        drain();
      end
    end

    // Wind-down: no more lines; any stray value beat still gets flagged.
    line_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.failures += sb.pending();

    $display("checked %0d value beats over %0d register settings", sb.beats_checked,
             settings_seen);
    $display("covered all curve codes, equal and reversed lines, a %0d-cycle hold",
             HOLD_CYCLES);
    if (sb.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failing beats", sb.failures);
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cvi_pkg.sv
rtl/cvi_if.sv
rtl/cvi_div.sv
rtl/curved_line_interpolator_top.sv
rtl/cvi_checker.sv
sim/tb_curved_line_interpolator_top.sv
